FILE: rtl/tics_pkg.sv
`default_nettype none

package tics_pkg;

	localparam int unsigned SEG_W = 21;
	localparam logic [SEG_W-1:0] MAX_SEGMENT_BYTES = 21'd1048576;

	localparam logic [31:0] TAG_FUJI = 32'h494A5546;
	localparam logic [31:0] TAG_BAUD = 32'h64756162;
	localparam logic [31:0] TAG_DATA = 32'h61746164;
	localparam logic [31:0] TAG_FSK  = 32'h206B7366;

	localparam logic [15:0] GAP_RESET  = 16'd10000;
	localparam logic [15:0] BAUD_RESET = 16'd1300;
	localparam logic [15:0] DROP_HEAD  = 16'd3;

	// register indexes
	localparam logic REG_GAP  = 1'b0;
	localparam logic REG_BAUD = 1'b1;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned MAX_RESULTS = 3;

	typedef enum logic [2:0] {
		KIND_PAYLOAD  = 3'd0,
		KIND_CLOSE    = 3'd1,
		KIND_TAG      = 3'd2,
		KIND_BAUD     = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       payload_byte;
		logic [6:0]       file_number;
		logic [SEG_W-1:0] segment_bytes;
	} rec_t;

	// results caused by one input word, count is 1..2
	typedef struct packed {
		logic [1:0]                  count;
		rec_t [MAX_RESULTS-1:0]      rec;
	} run_t;

	typedef struct packed {
		logic push;
		run_t run;
	} push_t;

	function automatic rec_t mk_rec(kind_t k, logic [7:0] b, logic [6:0] nm,
		logic [SEG_W-1:0] seg);
		rec_t r;
		r.kind          = k;
		r.payload_byte  = b;
		r.file_number   = nm;
		r.segment_bytes = seg;
		return r;
	endfunction

	// start count mod 100 for an 8-bit count
	function automatic logic [6:0] mod100(logic [7:0] v);
		logic [7:0] r;
		if (v >= 8'd200) begin
			r = v - 8'd200;
		end else if (v >= 8'd100) begin
			r = v - 8'd100;
		end else begin
			r = v;
		end
		return r[6:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/tics_ifs.sv
`default_nettype none

interface tics_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] image_byte;
	logic       final_byte;

	modport source(output valid, output image_byte, output final_byte, input ready);
	modport sink(input valid, input image_byte, input final_byte, output ready);
endinterface

interface tics_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  payload_byte;
	logic [6:0]  file_number;
	logic [20:0] segment_bytes;
	logic        last_of_run;

	modport source(output valid, output kind, output payload_byte, output file_number,
		output segment_bytes, output last_of_run, input ready);
	modport sink(input valid, input kind, input payload_byte, input file_number,
		input segment_bytes, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/tics_front.sv
`default_nettype none

module tics_front import tics_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tics_in_if.sink    image,
	input  wire logic  write_en,
	input  wire logic  reg_index,
	input  wire logic [15:0] write_data,
	input  wire logic  q_full,
	output push_t      push
);

	typedef enum logic [1:0] {
		CLS_HEADER = 2'd0,
		CLS_SKIP   = 2'd1,
		CLS_DATA   = 2'd2
	} class_t;

	logic [2:0]       hp_q, hp_n;
	logic [31:0]      tag_q, tag_n;
	logic [15:0]      len_q, len_n;
	logic [15:0]      aux_q, aux_n;
	logic [15:0]      rem_q, rem_n;
	class_t           class_q, class_n;
	logic [SEG_W-1:0] held_q, held_n;
	logic [7:0]       start_q, start_n;
	logic [6:0]       name_q, name_n;
	logic             stopped_q, stopped_n;
	logic [15:0]      gap_q, baud_q;

	logic             accept;
	logic [1:0]       n_v;
	rec_t [MAX_RESULTS-1:0] recs;
	logic [15:0]      idx;
	logic [7:0]       b;

	assign image.ready = !q_full;
	assign accept      = image.valid && image.ready;
	assign b           = image.image_byte;
	assign idx         = len_q - rem_q;

	always_comb begin
		hp_n      = hp_q;
		tag_n     = tag_q;
		len_n     = len_q;
		aux_n     = aux_q;
		rem_n     = rem_q;
		class_n   = class_q;
		held_n    = held_q;
		start_n   = start_q;
		name_n    = name_q;
		stopped_n = stopped_q;
		n_v       = 2'd0;
		recs      = '0;

		if (!stopped_q) begin
			if (class_q == CLS_HEADER) begin
				if (hp_q < 3'd4) begin
					tag_n = {b, tag_q[31:8]};
				end else if (hp_q < 3'd6) begin
					len_n = {b, len_q[15:8]};
				end else begin
					aux_n = {b, aux_q[15:8]};
				end
				hp_n = hp_q + 3'd1;
				if (hp_q == 3'd7) begin
					class_n = CLS_SKIP;
					rem_n   = len_n;
					if (tag_n == TAG_FUJI) begin
						class_n = CLS_SKIP;
					end else if (tag_n == TAG_BAUD) begin
						if (aux_n > baud_q) begin
							recs[n_v] = mk_rec(KIND_BAUD, 8'd0, name_n, '0);
							n_v = n_v + 2'd1;
							stopped_n = 1'b1;
						end
					end else if (tag_n == TAG_DATA || tag_n == TAG_FSK) begin
						if (tag_n == TAG_FSK || aux_n > gap_q) begin
							// segment start: close what is held, then renumber
							if (held_n != '0) begin
								recs[n_v] = mk_rec(KIND_CLOSE, 8'd0, name_n, held_n);
								n_v = n_v + 2'd1;
								held_n = '0;
							end
							if (start_q != 8'd0) begin
								name_n = mod100(start_q);
							end
							start_n = start_q + 8'd1;
						end
						if (tag_n == TAG_DATA) begin
							class_n = CLS_DATA;
						end
					end else begin
						recs[n_v] = mk_rec(KIND_TAG, 8'd0, name_n, '0);
						n_v = n_v + 2'd1;
						stopped_n = 1'b1;
					end
					if (stopped_n) begin
						if (held_n != '0) begin
							recs[n_v] = mk_rec(KIND_CLOSE, 8'd0, name_n, held_n);
							n_v = n_v + 2'd1;
							held_n = '0;
						end
					end else if (len_n == 16'd0) begin
						class_n = CLS_HEADER;
					end
				end
			end else begin
				rem_n = rem_q - 16'd1;
				// drop the three lead bytes and the checksum byte
				if (class_q == CLS_DATA && len_q >= 16'd5 && idx >= DROP_HEAD &&
					({1'b0, idx} + 17'd2) <= {1'b0, len_q}) begin
					if (held_n >= MAX_SEGMENT_BYTES) begin
						recs[n_v] = mk_rec(KIND_OVERFLOW, 8'd0, name_n, '0);
						n_v = n_v + 2'd1;
						recs[n_v] = mk_rec(KIND_CLOSE, 8'd0, name_n, held_n);
						n_v = n_v + 2'd1;
						held_n = '0;
						stopped_n = 1'b1;
					end else begin
						recs[n_v] = mk_rec(KIND_PAYLOAD, b, name_n, '0);
						n_v = n_v + 2'd1;
						held_n = held_n + 1'b1;
					end
				end
				if (rem_n == 16'd0) begin
					class_n = CLS_HEADER;
				end
			end

			if (image.final_byte && !stopped_n) begin
				if (held_n != '0) begin
					recs[n_v] = mk_rec(KIND_CLOSE, 8'd0, name_n, held_n);
					n_v = n_v + 2'd1;
					held_n = '0;
				end
				stopped_n = 1'b1;
			end
		end
	end

	assign push.push      = accept && (n_v != 2'd0);
	assign push.run.count = n_v;
	assign push.run.rec   = recs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q      <= '0;
			tag_q     <= '0;
			len_q     <= '0;
			aux_q     <= '0;
			rem_q     <= '0;
			class_q   <= CLS_HEADER;
			held_q    <= '0;
			start_q   <= '0;
			name_q    <= '0;
			stopped_q <= 1'b0;
			gap_q     <= GAP_RESET;
			baud_q    <= BAUD_RESET;
		end else begin
			if (accept) begin
				hp_q      <= hp_n;
				tag_q     <= tag_n;
				len_q     <= len_n;
				aux_q     <= aux_n;
				rem_q     <= rem_n;
				class_q   <= class_n;
				held_q    <= held_n;
				start_q   <= start_n;
				name_q    <= name_n;
				stopped_q <= stopped_n;
			end
			if (write_en) begin
				case (reg_index)
					REG_GAP:  gap_q  <= write_data;
					REG_BAUD: baud_q <= write_data;
					default:  gap_q  <= gap_q;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tics_queue.sv
`default_nettype none

module tics_queue import tics_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  push_t     push,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output run_t      head
);

	run_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_pop, do_push;

	assign full       = (cnt_q == QUEUE_DEPTH[QPTR_W:0]);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign do_pop     = pop && head_valid;
	assign do_push    = push.push && !full;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tics_back.sv
`default_nettype none

module tics_back import tics_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  run_t       head,
	output logic       pop,
	tics_out_if.source results
);

	run_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	rec_t       rec;
	logic       last;
	logic       fire;
	logic       load;

	assign rec  = cur_q.rec[idx_q];
	assign last = (idx_q == (cur_q.count - 2'd1));
	assign fire = results.valid && results.ready;
	assign load = !cur_valid_q || (fire && last);
	assign pop  = load && head_valid;

	assign results.valid         = cur_valid_q;
	assign results.kind          = rec.kind;
	assign results.payload_byte  = rec.payload_byte;
	assign results.file_number   = rec.file_number;
	assign results.segment_bytes = rec.segment_bytes;
	assign results.last_of_run   = last;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			cur_valid_q <= head_valid;
			idx_q       <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tape_image_chunk_splitter.sv
// channel    dir  word
// image      in   image_byte, final_byte
// results    out  kind, payload_byte, file_number, segment_bytes, last_of_run
// write_*    in   reg_index selects gap threshold (0) or baud limit (1)
//
// one image byte is taken per cycle except while the queue is full, when image.ready
// drops; header and counter updates finish in that cycle; a byte's results pass a
// four-deep queue and leave one per cycle while results.ready is high, so a
// two-result byte holds the output for both; nothing needs clearing after reset

`default_nettype none

module tape_image_chunk_splitter import tics_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tics_in_if.sink          image,
	tics_out_if.source       results,
	input  wire logic        write_en,
	input  wire logic        reg_index,
	input  wire logic [15:0] write_data
);

	push_t push;
	logic  q_full;
	logic  pop;
	logic  head_valid;
	run_t  head;

	tics_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.image      (image),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data),
		.q_full     (q_full),
		.push       (push)
	);

	tics_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	tics_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.results    (results)
	);

endmodule

`default_nettype wire
